### rtl/core/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types, codes and constants of the sorted timeout queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int TIME_W        = 48;
    localparam int DELAY_W       = 24;
    localparam int WAIT_W        = 25;
    localparam int US_PER_MS     = 1000;
    localparam int TABLE_DEPTH_D = 16;
    localparam int ID_BITS_D     = 16;
    localparam logic [WAIT_W-2:0] WAIT_MAX = '1;

    // Request kinds carried in tuser.
    typedef enum logic [2:0] {
        REQ_START     = 3'd0,
        REQ_CANCEL_ID = 3'd1,
        REQ_CANCEL_AG = 3'd2,
        REQ_CANCEL_MT = 3'd3,
        REQ_ACTIVE    = 3'd4,
        REQ_WAIT      = 3'd5,
        REQ_POLL      = 3'd6,
        REQ_TAKE      = 3'd7
    } req_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

endpackage : stq_pkg
`default_nettype wire

### rtl/core/sorted_timeout_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timeout_queue
// Deadline-ordered timer table walked one entry per cycle by a sequencer.
// ----------------------------------------------------------------------------
// A start computes its deadline, searches for the insert slot and shifts the entries
// behind it (search and shift walks together cover the table once); a refused start
// answers from dispatch. Cancel id and active search the table; agent cancels shift
// out each match. Poll and take mark due entries from the head; take drops the head.
// Wait runs the reciprocal divide by 1000 only when the head is not yet due.
// Throughput: one transaction at a time; s_tready is low until the result is taken.
// Reset: synchronous active-low aresetn empties the table and zeroes the id counter.
module sorted_timeout_queue #(
    parameter int TABLE_DEPTH = stq_pkg::TABLE_DEPTH_D,
    parameter int ID_BITS     = stq_pkg::ID_BITS_D
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // now_us[47:0], timer_ref[63:48], agent_ref[79:64], delay_ms[103:80],
    // user_data[135:104], label_tag[151:136]
    input  wire logic [151:0] s_tdata,
    // req_type[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], got_timer[17:2], got_agent[33:18], got_data[65:34],
    // got_tag[81:66], flag[82], wait_ms[107:83], zero fill[111:108]
    output logic [111:0]      m_tdata
);
    import stq_pkg::*;

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int CW   = (ID_BITS > 16) ? ID_BITS : 16;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_PLACE = 10'b0000001000,
        S_SCAN  = 10'b0000010000,
        S_SHIFT = 10'b0000100000,
        S_DROP  = 10'b0001000000,
        S_MARK  = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_DIV   = 10'b1000000000
    } state_t;

    // Timer table.
    logic [TIME_W-1:0]  dl_reg  [TABLE_DEPTH];
    logic [ID_BITS-1:0] id_reg  [TABLE_DEPTH];
    logic [15:0]        ag_reg  [TABLE_DEPTH];
    logic [31:0]        dat_reg [TABLE_DEPTH];
    logic [15:0]        tag_reg [TABLE_DEPTH];
    logic               exp_reg [TABLE_DEPTH];

    state_t             state_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic [ID_BITS-1:0] ctr_reg;
    logic [CNTW-1:0]    ptr_reg;
    logic [CNTW-1:0]    pos_reg;
    logic               mark_reg;
    logic               gone_reg;
    logic [33:0]        prod_reg;
    logic [TIME_W-1:0]  when_reg;

    // Latched request.
    req_t               req_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [15:0]        tref_reg;
    logic [15:0]        agent_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [31:0]        data_reg;
    logic [15:0]        ltag_reg;

    // Result register.
    logic               m_valid_reg;
    status_t            st_reg;
    logic [15:0]        gtimer_reg;
    logic [15:0]        gagent_reg;
    logic [31:0]        gdata_reg;
    logic [15:0]        gtag_reg;
    logic               flag_reg;
    logic [WAIT_W-1:0]  wait_reg;

    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [TIME_W-1:0]  div_quo;

    logic [IW-1:0]      pi;
    logic [IW-1:0]      pim1;
    logic [IW-1:0]      pip1;
    logic [IW-1:0]      posi;
    logic               in_range;
    logic               id_hit;
    logic               ag_hit;
    logic [TIME_W-1:0]  when_c;
    logic [ID_BITS-1:0] new_id;
    logic [CW-1:0]      new_id_w;
    logic               start_mark;

    assign pi       = ptr_reg[IW-1:0];
    assign pim1     = IW'(ptr_reg - 1'b1);
    assign pip1     = IW'(ptr_reg + 1'b1);
    assign posi     = pos_reg[IW-1:0];
    assign in_range = (ptr_reg < cnt_reg);
    assign id_hit   = (CW'(id_reg[pi]) == CW'(tref_reg));
    assign ag_hit   = (ag_reg[pi] == agent_reg) &&
                      ((req_reg != REQ_CANCEL_MT) ||
                       ((dat_reg[pi] == data_reg) && (tag_reg[pi] == ltag_reg)));
    assign when_c   = now_reg + TIME_W'(prod_reg);
    assign new_id   = (ctr_reg == '0) ? ID_BITS'(1) : ctr_reg;
    assign new_id_w = CW'(new_id);

    // Mark of a new entry placed after the head, at the current walk pointer.
    always_comb begin
        if (delay_reg == '0) begin
            start_mark = 1'b1;
        end else if (dl_reg[pim1] == when_reg) begin
            start_mark = exp_reg[pim1];
        end else if (in_range) begin
            start_mark = exp_reg[pi];
        end else begin
            start_mark = 1'b0;
        end
    end

    assign div_start = (state_reg == S_DISP) && (req_reg == REQ_WAIT) &&
                       (cnt_reg != '0) && (dl_reg[0] > now_reg);

    stq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dl_reg[0] - now_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;

    // Sequencer and table updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            ctr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        req_reg    <= req_t'(s_tuser);
                        now_reg    <= s_tdata[47:0];
                        tref_reg   <= s_tdata[63:48];
                        agent_reg  <= s_tdata[79:64];
                        delay_reg  <= s_tdata[103:80];
                        data_reg   <= s_tdata[135:104];
                        ltag_reg   <= s_tdata[151:136];
                        st_reg     <= ST_NONE;
                        gtimer_reg <= '0;
                        gagent_reg <= '0;
                        gdata_reg  <= '0;
                        gtag_reg   <= '0;
                        flag_reg   <= 1'b0;
                        wait_reg   <= '0;
                        gone_reg   <= 1'b0;
                        ptr_reg    <= '0;
                        state_reg  <= S_DISP;
                    end
                end
                S_DISP: begin
                    unique case (req_reg) inside
                        REQ_START: begin
                            if (agent_reg == '0) begin
                                st_reg      <= ST_INVALID;
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end else if (cnt_reg >= CNTW'(TABLE_DEPTH)) begin
                                st_reg      <= ST_FULL;
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end else begin
                                state_reg <= S_MUL;
                            end
                        end
                        REQ_CANCEL_ID, REQ_ACTIVE: begin
                            if (tref_reg == '0) begin
                                st_reg      <= ST_INVALID;
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end else begin
                                state_reg <= S_SCAN;
                            end
                        end
                        REQ_CANCEL_AG, REQ_CANCEL_MT: begin
                            if (agent_reg == '0) begin
                                st_reg      <= ST_INVALID;
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end else begin
                                state_reg <= S_SCAN;
                            end
                        end
                        REQ_WAIT: begin
                            if (cnt_reg == '0) begin
                                wait_reg    <= '1;
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end else if (dl_reg[0] > now_reg) begin
                                state_reg <= S_DIV;
                            end else begin
                                st_reg      <= ST_OK;
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end
                        end
                        REQ_POLL, REQ_TAKE: begin
                            if ((cnt_reg != '0) && !exp_reg[0]) begin
                                state_reg <= S_MARK;
                            end else begin
                                state_reg <= S_FIN;
                            end
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_MUL: begin
                    prod_reg  <= 34'(delay_reg) * 34'(US_PER_MS);
                    state_reg <= S_PLACE;
                end
                S_PLACE: begin
                    when_reg <= when_c;
                    if (cnt_reg == '0) begin
                        ptr_reg   <= cnt_reg;
                        pos_reg   <= '0;
                        mark_reg  <= (delay_reg == '0);
                        state_reg <= S_SHIFT;
                    end else if (when_c < dl_reg[0]) begin
                        ptr_reg   <= cnt_reg;
                        pos_reg   <= '0;
                        mark_reg  <= exp_reg[0];
                        state_reg <= S_SHIFT;
                    end else begin
                        ptr_reg   <= CNTW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    case (req_reg) inside
                        REQ_START: begin
                            if (in_range && (when_reg >= dl_reg[pi])) begin
                                ptr_reg <= ptr_reg + 1'b1;
                            end else begin
                                pos_reg   <= ptr_reg;
                                mark_reg  <= start_mark;
                                ptr_reg   <= cnt_reg;
                                state_reg <= S_SHIFT;
                            end
                        end
                        REQ_CANCEL_ID, REQ_ACTIVE: begin
                            if (!in_range) begin
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end else if (id_hit) begin
                                st_reg <= ST_OK;
                                if (req_reg == REQ_ACTIVE) begin
                                    flag_reg    <= 1'b1;
                                    m_valid_reg <= 1'b1;
                                    state_reg   <= S_IDLE;
                                end else begin
                                    pos_reg   <= ptr_reg;
                                    state_reg <= S_DROP;
                                end
                            end else begin
                                ptr_reg <= ptr_reg + 1'b1;
                            end
                        end
                        default: begin
                            if (!in_range) begin
                                st_reg      <= gone_reg ? ST_OK : ST_NONE;
                                m_valid_reg <= 1'b1;
                                state_reg   <= S_IDLE;
                            end else if (ag_hit) begin
                                gone_reg  <= 1'b1;
                                pos_reg   <= ptr_reg;
                                state_reg <= S_DROP;
                            end else begin
                                ptr_reg <= ptr_reg + 1'b1;
                            end
                        end
                    endcase
                end
                // Open a slot at the insert position, one entry per cycle.
                S_SHIFT: begin
                    if (ptr_reg > pos_reg) begin
                        dl_reg[pi]  <= dl_reg[pim1];
                        id_reg[pi]  <= id_reg[pim1];
                        ag_reg[pi]  <= ag_reg[pim1];
                        dat_reg[pi] <= dat_reg[pim1];
                        tag_reg[pi] <= tag_reg[pim1];
                        exp_reg[pi] <= exp_reg[pim1];
                        ptr_reg     <= ptr_reg - 1'b1;
                    end else begin
                        dl_reg[posi]  <= when_reg;
                        id_reg[posi]  <= new_id;
                        ag_reg[posi]  <= agent_reg;
                        dat_reg[posi] <= data_reg;
                        tag_reg[posi] <= ltag_reg;
                        exp_reg[posi] <= mark_reg;
                        cnt_reg       <= cnt_reg + 1'b1;
                        ctr_reg       <= new_id + 1'b1;
                        gtimer_reg    <= new_id_w[15:0];
                        st_reg        <= ST_OK;
                        m_valid_reg   <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                // Close the slot at the drop position, one entry per cycle.
                S_DROP: begin
                    if ((pos_reg + 1'b1) < cnt_reg) begin
                        dl_reg[posi]  <= dl_reg[IW'(pos_reg + 1'b1)];
                        id_reg[posi]  <= id_reg[IW'(pos_reg + 1'b1)];
                        ag_reg[posi]  <= ag_reg[IW'(pos_reg + 1'b1)];
                        dat_reg[posi] <= dat_reg[IW'(pos_reg + 1'b1)];
                        tag_reg[posi] <= tag_reg[IW'(pos_reg + 1'b1)];
                        exp_reg[posi] <= exp_reg[IW'(pos_reg + 1'b1)];
                        pos_reg       <= pos_reg + 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                        if ((req_reg == REQ_CANCEL_AG) || (req_reg == REQ_CANCEL_MT)) begin
                            state_reg <= S_SCAN;
                        end else begin
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                // Mark due entries from the head.
                S_MARK: begin
                    if (in_range && (now_reg >= dl_reg[pi])) begin
                        exp_reg[pi] <= 1'b1;
                        ptr_reg     <= ptr_reg + 1'b1;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if ((cnt_reg != '0) && exp_reg[0]) begin
                        flag_reg <= 1'b1;
                        st_reg   <= ST_OK;
                        if (req_reg == REQ_TAKE) begin
                            gtimer_reg <= CW'(id_reg[0]) >> 0 == '0 ? 16'd0 :
                                          16'(CW'(id_reg[0]));
                            gagent_reg <= ag_reg[0];
                            gdata_reg  <= dat_reg[0];
                            gtag_reg   <= tag_reg[0];
                            pos_reg    <= '0;
                            state_reg  <= S_DROP;
                        end else begin
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                    end else begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        st_reg <= ST_OK;
                        if (div_quo > TIME_W'(WAIT_MAX)) begin
                            wait_reg <= {1'b0, WAIT_MAX};
                        end else begin
                            wait_reg <= WAIT_W'(div_quo);
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, wait_reg, flag_reg, gtag_reg, gdata_reg,
                       gagent_reg, gtimer_reg, st_reg};

    // The table never holds more entries than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // The entry count moves by at most one per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != $past(cnt_reg)) |->
        ((cnt_reg == $past(cnt_reg) + 1'b1) || (cnt_reg + 1'b1 == $past(cnt_reg))))
        else $error("entry count jumped");

    // A full status is only reported with a full table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (st_reg == ST_FULL)) |-> (cnt_reg == CNTW'(TABLE_DEPTH)))
        else $error("full status with room in the table");

    // The divider only runs while the sequencer waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider busy outside its wait state");

endmodule : sorted_timeout_queue
`default_nettype wire

### rtl/core/stq_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_div
// Divides a time difference by one thousand with a reciprocal multiply.
// Differences at or above the saturation limit return all ones.
// ----------------------------------------------------------------------------
module stq_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [stq_pkg::TIME_W-1:0] dividend,
    output logic                            busy,
    output logic                            done,
    output logic [stq_pkg::TIME_W-1:0]      quotient
);
    import stq_pkg::*;

    // Dividing by 1000 is a shift by 3 and a divide by 125. Below the
    // saturation limit the shifted value fits 31 bits, where the rounded-up
    // reciprocal 2^38/125 gives the exact floor.
    localparam int                Y_W       = 31;
    localparam int                P_W       = Y_W + 32;
    localparam int                SHIFT     = 38;
    localparam logic [31:0]       RECIP     = 32'd2199023256;
    // (WAIT_MAX + 1) * 1000: every larger difference saturates.
    localparam logic [TIME_W-1:0] SAT_LIMIT = TIME_W'(64'd16777216000);

    logic [Y_W-1:0] y_reg;
    logic           sat_reg;
    logic [P_W-1:0] prod_reg;
    logic [1:0]     stage_reg;
    logic           busy_reg;
    logic           done_reg;

    // Load, multiply, then report.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            stage_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                stage_reg <= 2'd2;
                sat_reg   <= (dividend >= SAT_LIMIT);
                y_reg     <= dividend[Y_W+2:3];
            end else if (busy_reg) begin
                if (stage_reg == 2'd2) begin
                    prod_reg  <= P_W'(y_reg) * P_W'(RECIP);
                    stage_reg <= 2'd1;
                end else begin
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                    stage_reg <= '0;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = sat_reg ? '1 : TIME_W'(prod_reg[P_W-1:SHIFT]);

endmodule : stq_div
`default_nettype wire

### sim/sorted_timeout_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_queue_checker
// Watches both channels of the timer queue, predicts each result from its
// own copy of the timer table and compares every result field by field.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [151:0] s_tdata,
    input  wire logic [2:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [111:0] m_tdata,
    output int                fail_count,
    output int                pending_count
);
    import stq_pkg::*;

    // Fields from the highest bit down; status sits in the lowest bits.
    typedef struct packed {
        logic [24:0] wait_ms;
        logic        flag;
        logic [15:0] got_tag;
        logic [31:0] got_data;
        logic [15:0] got_agent;
        logic [15:0] got_timer;
        logic [1:0]  status;
    } timer_result_t;

    localparam int DEPTH = TABLE_DEPTH_D;

    // Shadow timer table.
    logic [47:0] tbl_deadline [DEPTH];
    logic [15:0] tbl_id       [DEPTH];
    logic [15:0] tbl_agent    [DEPTH];
    logic [31:0] tbl_data     [DEPTH];
    logic [15:0] tbl_tag      [DEPTH];
    logic        tbl_expired  [DEPTH];
    int          tbl_count;
    logic [15:0] next_id;

    timer_result_t expected_results [$];

    assign pending_count = expected_results.size();

    // Remove one slot, closing the gap.
    function automatic void remove_slot(int idx);
        for (int k = idx; k + 1 < tbl_count; k++) begin
            tbl_deadline[k] = tbl_deadline[k+1];
            tbl_id[k]       = tbl_id[k+1];
            tbl_agent[k]    = tbl_agent[k+1];
            tbl_data[k]     = tbl_data[k+1];
            tbl_tag[k]      = tbl_tag[k+1];
            tbl_expired[k]  = tbl_expired[k+1];
        end
        tbl_count--;
    endfunction

    // Mark due entries from the head unless the head is already marked.
    function automatic void mark_due_entries(logic [47:0] now);
        if (tbl_count == 0 || tbl_expired[0]) return;
        for (int i = 0; i < tbl_count && now >= tbl_deadline[i]; i++)
            tbl_expired[i] = 1'b1;
    endfunction

    function automatic timer_result_t apply_request(req_t req, logic [151:0] d);
        timer_result_t r;
        logic [47:0]   now;
        logic [15:0]   tref, agent, tag;
        logic [23:0]   delay;
        logic [31:0]   data;
        logic [47:0]   due;
        logic          mark;
        logic [47:0]   ms;
        int            p, gone;
        now   = d[47:0];
        tref  = d[63:48];
        agent = d[79:64];
        delay = d[103:80];
        data  = d[135:104];
        tag   = d[151:136];
        r = '0;
        r.status = ST_NONE;
        case (req) inside
            REQ_START: begin
                if (agent == 0) begin
                    r.status = ST_INVALID;
                end else if (tbl_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (next_id == 0) next_id = 1;
                    r.got_timer = next_id;
                    next_id = next_id + 16'd1;
                    due  = now + 48'(delay) * 48'd1000;
                    mark = (delay == 0);
                    if (tbl_count == 0) begin
                        p = 0;
                    end else if (due < tbl_deadline[0]) begin
                        p = 0;
                        mark = tbl_expired[0];
                    end else begin
                        p = 1;
                        while (p < tbl_count && due >= tbl_deadline[p]) p++;
                        if (delay != 0) begin
                            if (tbl_deadline[p-1] == due) mark = tbl_expired[p-1];
                            else if (p < tbl_count) mark = tbl_expired[p];
                        end
                    end
                    for (int i = tbl_count; i > p; i--) begin
                        tbl_deadline[i] = tbl_deadline[i-1];
                        tbl_id[i]       = tbl_id[i-1];
                        tbl_agent[i]    = tbl_agent[i-1];
                        tbl_data[i]     = tbl_data[i-1];
                        tbl_tag[i]      = tbl_tag[i-1];
                        tbl_expired[i]  = tbl_expired[i-1];
                    end
                    tbl_deadline[p] = due;
                    tbl_id[p]       = r.got_timer;
                    tbl_agent[p]    = agent;
                    tbl_data[p]     = data;
                    tbl_tag[p]      = tag;
                    tbl_expired[p]  = mark;
                    tbl_count++;
                    r.status = ST_OK;
                end
            end
            REQ_CANCEL_ID, REQ_ACTIVE: begin
                if (tref == 0) begin
                    r.status = ST_INVALID;
                end else begin
                    for (int i = 0; i < tbl_count; i++) begin
                        if (tbl_id[i] == tref) begin
                            r.status = ST_OK;
                            if (req == REQ_CANCEL_ID) remove_slot(i);
                            else r.flag = 1'b1;
                            break;
                        end
                    end
                end
            end
            REQ_CANCEL_AG, REQ_CANCEL_MT: begin
                if (agent == 0) begin
                    r.status = ST_INVALID;
                end else begin
                    p = 0;
                    gone = 0;
                    while (p < tbl_count) begin
                        if (tbl_agent[p] == agent && (req == REQ_CANCEL_AG ||
                            (tbl_data[p] == data && tbl_tag[p] == tag))) begin
                            remove_slot(p);
                            gone++;
                        end else begin
                            p++;
                        end
                    end
                    r.status = (gone != 0) ? ST_OK : ST_NONE;
                end
            end
            REQ_WAIT: begin
                if (tbl_count == 0) begin
                    r.wait_ms = '1;
                end else begin
                    r.status = ST_OK;
                    if (tbl_deadline[0] > now) begin
                        ms = (tbl_deadline[0] - now) / 48'd1000;
                        r.wait_ms = (ms > 48'(WAIT_MAX)) ? 25'(WAIT_MAX) : 25'(ms);
                    end
                end
            end
            default: begin
                // Poll and take share the marking pass.
                mark_due_entries(now);
                if (tbl_count != 0 && tbl_expired[0]) begin
                    r.flag   = 1'b1;
                    r.status = ST_OK;
                    if (req == REQ_TAKE) begin
                        r.got_timer = tbl_id[0];
                        r.got_agent = tbl_agent[0];
                        r.got_data  = tbl_data[0];
                        r.got_tag   = tbl_tag[0];
                        remove_slot(0);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Predict on each accepted request and check each accepted result.
    always @(posedge aclk) begin
        timer_result_t want, got;
        if (!aresetn) begin
            tbl_count = 0;
            next_id   = '0;
            fail_count <= 0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[107:0];
                if (expected_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        fail_count <= fail_count + 1;
                        if (got.status != want.status)
                            $error("status exp %0d got %0d", want.status, got.status);
                        if (got.got_timer != want.got_timer)
                            $error("got_timer exp %0d got %0d", want.got_timer, got.got_timer);
                        if (got.got_agent != want.got_agent)
                            $error("got_agent exp %0d got %0d", want.got_agent, got.got_agent);
                        if (got.got_data != want.got_data)
                            $error("got_data exp %0d got %0d",
                                   $signed(want.got_data), $signed(got.got_data));
                        if (got.got_tag != want.got_tag)
                            $error("got_tag exp %0d got %0d", want.got_tag, got.got_tag);
                        if (got.flag != want.flag)
                            $error("flag exp %0d got %0d", want.flag, got.flag);
                        if (got.wait_ms != want.wait_ms)
                            $error("wait_ms exp %0d got %0d",
                                   $signed(want.wait_ms), $signed(got.wait_ms));
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(req_t'(s_tuser), s_tdata));
        end
    end

endmodule

### sim/sorted_timeout_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_queue_tb
// Drives directed and random timer requests into the timer queue under
// several idle and stall patterns; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_tb;
    import stq_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    int           fail_count;
    int           pending_count;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [47:0] clock_us = 48'd5000;
    logic [15:0] issued_ids [$];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sorted_timeout_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    sorted_timeout_queue_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Receiver readiness changes on falling edges.
    always @(negedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);

    // Send one request transaction, idling first at the current rate.
    // tvalid stays high after the handshake until the next call drives it.
    task automatic send_request(req_t req, logic [47:0] now, logic [15:0] tref,
                                logic [15:0] agent, logic [23:0] delay,
                                logic [31:0] data, logic [15:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tuser  <= req;
        s_tdata  <= {tag, data, delay, agent, tref, now};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Random request, mostly well formed around a slowly moving clock.
    task automatic send_random();
        req_t        req;
        logic [15:0] agent, tref;
        logic [23:0] delay;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 35) req = REQ_START;
        else req = req_t'($urandom_range(7));
        clock_us = clock_us + 48'($urandom_range(3000));
        if ($urandom_range(49) == 0) clock_us = 48'($urandom) << $urandom_range(16);
        agent = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        case ($urandom_range(9))
            0: delay = 24'($urandom);
            1: delay = 0;
            default: delay = 24'($urandom_range(8));
        endcase
        if (issued_ids.size() != 0 && $urandom_range(3) != 0)
            tref = issued_ids[$urandom_range(issued_ids.size() - 1)];
        else
            tref = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom);
        if (req == REQ_START && issued_ids.size() < 64)
            issued_ids.push_back(16'(issued_ids.size() + 1));
        send_request(req, clock_us, tref, agent, delay,
                     ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1)),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1)));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: invalid arguments, empty queries, fill to full, then query, take and cancel.
        send_request(REQ_START, 48'd100, 0, 0, 5, 0, 0);
        send_request(REQ_WAIT, 48'd100, 0, 0, 0, 0, 0);
        send_request(REQ_POLL, 48'd100, 0, 0, 0, 0, 0);
        send_request(REQ_TAKE, 48'd100, 0, 0, 0, 0, 0);
        send_request(REQ_CANCEL_ID, 48'd100, 0, 1, 0, 0, 0);
        send_request(REQ_ACTIVE, 48'd100, 0, 1, 0, 0, 0);
        send_request(REQ_CANCEL_AG, 48'd100, 0, 0, 0, 0, 0);
        send_request(REQ_CANCEL_MT, 48'd100, 0, 0, 0, 0, 0);
        send_request(REQ_START, '1, 0, 16'hFFFF, 24'hFFFFFF, 32'h8000_0000, 16'hFFFF);
        send_request(REQ_WAIT, 48'd0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            send_request(REQ_START, 48'd2000, 0, 16'(i % 3 + 1), 24'(i % 4),
                         32'h7FFF_FFFF, 16'(i));
        send_request(REQ_ACTIVE, 48'd2000, 16'd3, 0, 0, 0, 0);
        send_request(REQ_WAIT, 48'd9000, 0, 0, 0, 0, 0);
        send_request(REQ_POLL, 48'd4000, 0, 0, 0, 0, 0);
        send_request(REQ_TAKE, 48'd4000, 0, 0, 0, 0, 0);
        send_request(REQ_CANCEL_ID, 48'd0, 16'd5, 0, 0, 0, 0);
        send_request(REQ_CANCEL_MT, 48'd0, 0, 16'd2, 0, 32'h7FFF_FFFF, 16'd4);
        send_request(REQ_CANCEL_AG, 48'd0, 0, 16'd1, 0, 0, 0);

        // Random: four phases of idle and stall rates.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 76) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 76) : 0;
            repeat (100) send_random();
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Timeout guard.
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
rtl/core/stq_pkg.sv
rtl/core/stq_div.sv
rtl/core/sorted_timeout_queue.sv
sim/sorted_timeout_queue_checker.sv
sim/sorted_timeout_queue_tb.sv
